### design/bme_pkg.sv
package bme_pkg;

    // Width of the offset plaintext value: 255 + 2 needs nine bits.
    localparam int BASE_BITS = 9;
    localparam int PLAIN_OFFSET = 2;

    // Register indexes, taken from paddr[2].
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_BASE      = 8'b0000_0010,
        S_WAIT_BASE = 8'b0000_0100,
        S_CHECK     = 8'b0000_1000,
        S_WAIT_ACC  = 8'b0001_0000,
        S_SQR       = 8'b0010_0000,
        S_WAIT_SQR  = 8'b0100_0000,
        S_FINISH    = 8'b1000_0000
    } seq_state_t;

    typedef enum logic [1:0] {
        MM_IDLE = 2'b01,
        MM_RED  = 2'b10
    } mm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

### design/bme_cfg.sv
module bme_cfg
    import bme_pkg::*;
#(
    parameter int MOD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [31:0]         exponent,
    output logic [MOD_BITS-1:0] modulus
);

    logic [31:0]         exp_reg;
    logic [31:0]         exp_next;
    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] mod_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        exp_next = exp_reg;
        mod_next = mod_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_EXPONENT:
                begin
                    exp_next = pwdata;
                end
                REG_MODULUS:
                begin
                    // A zero modulus is refused and the old value stays.
                    if (pwdata[MOD_BITS-1:0] != '0)
                    begin
                        mod_next = pwdata[MOD_BITS-1:0];
                    end
                end
                default:
                begin
                    exp_next = exp_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
            mod_reg <= MOD_BITS'(1);
        end
        else
        begin
            exp_reg <= exp_next;
            mod_reg <= mod_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EXPONENT: prdata = exp_reg;
            REG_MODULUS:  prdata = 32'(mod_reg);
            default:      prdata = '0;
        endcase
    end

    assign exponent = exp_reg;
    assign modulus  = mod_reg;

endmodule

### design/bme_modmul.sv
module bme_modmul
    import bme_pkg::*;
#(
    parameter int MOD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [((MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS)-1:0] op_a,
    input  logic [((MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS)-1:0] op_b,
    input  logic [MOD_BITS-1:0] modulus,
    output logic [MOD_BITS-1:0] result,
    output mm_status_t          status
);

    localparam int OW = (MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS;
    localparam int PW = 2 * OW;
    localparam int CW = $clog2(PW);

    mm_state_t           state_reg;
    mm_state_t           state_next;
    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       prod_next;
    logic [MOD_BITS-1:0] rem_reg;
    logic [MOD_BITS-1:0] rem_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                done_reg;
    logic                done_next;
    logic [MOD_BITS:0]   rem_shift;
    logic [MOD_BITS:0]   rem_sub;
    logic [MOD_BITS:0]   mod_ext;

    // Restoring reduction: one product bit enters the remainder per cycle.
    assign mod_ext   = {1'b0, modulus};
    assign rem_shift = {rem_reg, prod_reg[PW-1]};
    assign rem_sub   = rem_shift - mod_ext;

    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    prod_next  = PW'(op_a) * PW'(op_b);
                    rem_next   = '0;
                    cnt_next   = CW'(PW - 1);
                    state_next = MM_RED;
                end
            end
            MM_RED:
            begin
                prod_next = {prod_reg[PW-2:0], 1'b0};
                if (rem_shift >= mod_ext)
                begin
                    rem_next = rem_sub[MOD_BITS-1:0];
                end
                else
                begin
                    rem_next = rem_shift[MOD_BITS-1:0];
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(0))
                begin
                    done_next  = 1'b1;
                    state_next = MM_IDLE;
                end
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign result      = rem_reg;
    assign status.busy = (state_reg == MM_RED);
    assign status.done = done_reg;

    // The partial remainder always stays below the modulus.
    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MM_RED) |-> (rem_reg < modulus))
        else $error("partial remainder reached the modulus");

endmodule

### design/byte_modexp_encrypt_core.sv
// Each modular multiply loads the product of its operands, runs one restoring
// reduction step per bit of the 2*W-bit product and flags done, W = max(MOD_BITS, 9).
// One multiply reduces the base, one runs per set exponent bit and one square per
// exponent bit below the top one; S_FINISH then registers the result for out_valid.
// A new byte is refused until then; every multiply uses the one shared unit.
// Reset clears the sequencer and output valid, and sets exponent 0, modulus 1.
module byte_modexp_encrypt_core
    import bme_pkg::*;
#(
    parameter int MOD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  plain_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] cipher_word
);

    localparam int OW = (MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS;

    logic [31:0]         exponent;
    logic [MOD_BITS-1:0] modulus;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic [31:0]         exp_reg;
    logic [31:0]         exp_next;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] acc_next;
    logic [MOD_BITS-1:0] sq_reg;
    logic [MOD_BITS-1:0] sq_next;
    logic [7:0]          byte_reg;
    logic [7:0]          byte_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [31:0]         out_word_reg;
    logic [31:0]         out_word_next;

    logic                mm_start;
    logic [OW-1:0]       mm_a;
    logic [OW-1:0]       mm_b;
    logic [MOD_BITS-1:0] mm_result;
    mm_status_t          mm_status;

    bme_cfg #(
        .MOD_BITS (MOD_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .exponent (exponent),
        .modulus  (modulus)
    );

    bme_modmul #(
        .MOD_BITS (MOD_BITS)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus),
        .result  (mm_result),
        .status  (mm_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        mm_start       = 1'b0;
        mm_a           = OW'(acc_reg);
        mm_b           = OW'(sq_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = plain_byte;
                    exp_next  = exponent;
                    // With modulus one every residue is zero, even for exponent zero.
                    acc_next   = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                // The base is reduced by multiplying it by one.
                mm_start   = 1'b1;
                mm_a       = OW'(byte_reg) + OW'(PLAIN_OFFSET);
                mm_b       = OW'(1);
                state_next = S_WAIT_BASE;
            end
            S_WAIT_BASE:
            begin
                if (mm_status.done)
                begin
                    sq_next    = mm_result;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    state_next = S_WAIT_ACC;
                end
                else
                begin
                    state_next = S_SQR;
                end
            end
            S_WAIT_ACC:
            begin
                if (mm_status.done)
                begin
                    acc_next   = mm_result;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                exp_next = {1'b0, exp_reg[31:1]};
                // The square after the top exponent bit would go unused.
                if (exp_reg[31:1] == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mm_start   = 1'b1;
                    mm_a       = OW'(sq_reg);
                    state_next = S_WAIT_SQR;
                end
            end
            S_WAIT_SQR:
            begin
                if (mm_status.done)
                begin
                    sq_next    = mm_result;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_word_next  = 32'(acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        byte_reg     <= byte_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cipher_word = out_word_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_BASE))
        else $error("accepted transfer did not start the sequencer");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> !mm_status.busy)
        else $error("multiply started while the unit was busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_status.done |-> (state_reg == S_WAIT_BASE || state_reg == S_WAIT_ACC ||
                            state_reg == S_WAIT_SQR))
        else $error("multiply result arrived outside a wait state");

    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cipher_word < 32'(modulus)))
        else $error("result not reduced below the modulus");

endmodule

### tb/sv/byte_modexp_encrypt_core_tb.sv
`timescale 1ns / 1ps

module byte_modexp_encrypt_core_tb
    import bme_pkg::*;
();

    localparam int CYCLE_LIMIT = 4_000_000;

    class cipher_scoreboard;
        logic [31:0] exponent;
        logic [31:0] modulus;
        logic [31:0] cipher_q[$];
        int errors;
        int checked;
        int settings;

        function new();
            exponent = 32'd0;
            modulus = 32'd1;
            errors = 0;
            checked = 0;
            settings = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            settings++;
            if (idx == REG_EXPONENT)
                exponent = value;
            else if (value != 32'd0)
                modulus = value;
        endfunction

        // Right-to-left square-and-multiply; residues stay below 2^32, so
        // every product fits in 64 bits.
        function logic [31:0] modexp(logic [8:0] base);
            logic [63:0] acc;
            logic [63:0] sq;
            logic [63:0] m;
            logic [31:0] e;
            if (modulus <= 32'd1)
                return 32'd0;
            m = {32'd0, modulus};
            acc = 64'd1;
            sq = {55'd0, base} % m;
            e = exponent;
            while (e != 32'd0)
            begin
                if (e[0])
                    acc = (acc * sq) % m;
                e = e >> 1;
                sq = (sq * sq) % m;
            end
            return acc[31:0];
        endfunction

        function void note_plain(logic [7:0] b);
            cipher_q.insert(cipher_q.size(), modexp({1'b0, b} + 9'(PLAIN_OFFSET)));
        endfunction

        function void check_cipher(logic [31:0] w);
            logic [31:0] want;
            if (cipher_q.size() == 0)
            begin
                $error("cipher_word %h arrived with no expected result", w);
                errors++;
                return;
            end
            want = cipher_q.pop_front();
            checked++;
            if (w !== want)
            begin
                $error("cipher_word mismatch: expected %h, got %h", want, w);
                errors++;
            end
        endfunction

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  plain_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] cipher_word;

    cipher_scoreboard sb = new();
    bit quiet = 1'b0;
    int cycles = 0;
    int stall_left = 0;

    byte_modexp_encrypt_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .plain_byte(plain_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cipher_word(cipher_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none while the quiet flag is set.
    function automatic int gap_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = gap_len();
        end
    end

    // Handshake signals are stable between the falling and the rising edge,
    // so a transfer is seen here at the falling edge before the rising edge on which it happens.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_cipher(cipher_word);
    end

    task automatic send_plain(input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        plain_byte <= b;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        sb.note_plain(b);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes one register, then reads it back in the following transfer.
    task automatic config_write(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, value);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        want = (idx == REG_EXPONENT) ? sb.exponent : sb.modulus;
        if (prdata !== want)
        begin
            $error("prdata mismatch: expected %h, got %h", want, prdata);
            sb.errors++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'hFFFF_FFFF;
        else if (r < 20)
            return $urandom_range(0, 3);
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] random_modulus();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(1, 300);
        else if (r < 25)
            return 32'd1 << $urandom_range(0, 31);
        else if (r < 35)
            return 32'hFFFF_FFFF;
        else if (r < 42)
            return 32'd0;
        return $urandom;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: modulus one gives zero even with a zero exponent.
        send_plain(8'h00);
        send_plain(8'hFF);
        settle();
        config_write(REG_MODULUS, 32'hFFFF_FFFF);
        send_plain(8'h00);
        send_plain(8'hFF);
        send_plain(8'h5A);
        settle();
        config_write(REG_EXPONENT, 32'hFFFF_FFFF);
        send_plain(8'h00);
        send_plain(8'hFF);
        send_plain(8'hA5);
        settle();
        // A zero modulus must leave the old one in place.
        config_write(REG_MODULUS, 32'd0);
        send_plain(8'h7F);
        settle();
        config_write(REG_MODULUS, 32'd257);
        config_write(REG_EXPONENT, 32'd3);
        send_plain(8'hFF);
        send_plain(8'hFE);
        send_plain(8'h01);
        settle();
        config_write(REG_MODULUS, 32'd2);
        config_write(REG_EXPONENT, 32'd1);
        send_plain(8'h00);
        send_plain(8'h01);
        settle();
        config_write(REG_MODULUS, 32'd1);
        send_plain(8'h80);
        settle();
        config_write(REG_EXPONENT, 32'd0);
        send_plain(8'h01);
        settle();
        config_write(REG_MODULUS, 32'hFFFF_FFFB);
        config_write(REG_EXPONENT, 32'd65537);
        send_plain(8'h00);
        send_plain(8'hFF);
        send_plain(8'h33);

        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            quiet = (phase == 2);
            config_write(REG_EXPONENT, random_exponent());
            config_write(REG_MODULUS, random_modulus());
            for (int i = 0; i < 20; i++)
            begin
                if (phase == 4 && i == 10)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                send_plain(8'($urandom_range(0, 255)));
            end
        end
        quiet = 1'b0;
        settle();
        repeat (20) @(posedge clk);

        $display("Checked %0d encrypted bytes across %0d register writes with read-back.",
                 sb.checked, sb.settings);
        $display("Covered modulus one, zero exponent, full-width exponent and modulus,");
        $display("an ignored zero modulus write, and random stalls on both channels.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
